FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms clocked on clk; DFE_ASSERT is disabled while active-low rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every clk edge outside reset
`define DFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every clk edge, reset included
`define DFE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/dfe_pkg.sv
// ----------------------------------------------------------------------------
// dfe_pkg
// Types, codes and sizes shared by the delimited field extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package dfe_pkg;

  // field counter width; counter saturates at all ones
  localparam int CNT_W = 24;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 16;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_ROW  = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_COL  = 4'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CPR  = 4'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_TYPE = 4'd3;

  // result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_INT  = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  // number parse phases
  localparam logic [1:0] NP_BLANK = 2'd0;
  localparam logic [1:0] NP_SIGN  = 2'd1;
  localparam logic [1:0] NP_DIGIT = 2'd2;
  localparam logic [1:0] NP_STOP  = 2'd3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;

  typedef struct packed {
    logic [1:0]  phase;
    logic        neg;
    logic [31:0] acc;
  } num_t;

  localparam num_t NUM_CLEAR = '{phase: NP_BLANK, neg: 1'b0, acc: 32'd0};

  // one queued request: first result, plus a trailing string end if has_end
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  fbyte;
    logic [31:0] mag;
    logic        neg;
    logic        valid;
    logic        has_end;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

FILE: rtl/dfe_in_if.sv
// ----------------------------------------------------------------------------
// dfe_in_if
// Text byte channel: valid/ready with one byte and an end-of-text flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

FILE: rtl/dfe_out_if.sv
// ----------------------------------------------------------------------------
// dfe_out_if
// Result channel: valid/ready carrying one result per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfe_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic [7:0]         field_byte;
  logic signed [31:0] int_value;
  logic               number_valid;
  logic               last_of_run;

  modport source (output valid, output result_kind, output field_byte, output int_value,
                  output number_valid, output last_of_run, input ready);
  modport sink   (input valid, input result_kind, input field_byte, input int_value,
                  input number_valid, input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: rtl/dfe_cfg_if.sv
// ----------------------------------------------------------------------------
// dfe_cfg_if
// Register write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfe_cfg_if;
  import dfe_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/delimited_field_extractor_core.sv
// ----------------------------------------------------------------------------
// delimited_field_extractor_core
// Tab/newline field extractor with string and integer output modes.
// ----------------------------------------------------------------------------
// Accepts one text byte per clock while the queue has room and no register
// write holds the input off. Bytes are classified in the front stage, which
// keeps the field counter and the number parser and so decides a byte's
// results in the cycle it is taken; requests then pass through a four-entry
// queue to the result register. Each result takes the output on its own, so
// a final string byte flagged end_of_text yields two results (byte plus end
// marker), and a stalled output fills the queue before the input stalls.
// After every register write the input is held off in the cycle after it
// while the wanted field index is recomputed and registered.
`default_nettype none

module delimited_field_extractor_core (
  input logic        clk,
  input logic        rst_n,
  dfe_in_if.sink     in_ch,
  dfe_out_if.source  out_ch,
  dfe_cfg_if.sink    cfg_ch
);
  import dfe_pkg::*;

  logic    push;
  job_t    push_job;
  logic    pop;
  job_t    head;
  q_stat_t q_stat;

  dfe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  dfe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  dfe_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

FILE: rtl/dfe_front.sv
// ----------------------------------------------------------------------------
// dfe_front
// Holds the registers and scan state, classifies each byte and queues the
// results it causes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dfe_front (
  input  logic            clk,
  input  logic            rst_n,
  dfe_in_if.sink          in_ch,
  dfe_cfg_if.sink         cfg_ch,
  input  dfe_pkg::q_stat_t q_stat,
  output logic            push,
  output dfe_pkg::job_t   push_job
);
  import dfe_pkg::*;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  logic [15:0]      row_r;
  logic [7:0]       col_r;
  logic [7:0]       cpr_r;
  logic             vt_r;
  logic [CNT_W-1:0] tgt_r;
  logic             tgt_ok_r;
  logic             hold_r;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             scan_r, scan_nxt;
  num_t             num_r, num_nxt;

  logic              cfg_fire;
  logic              in_fire;
  logic [7:0]        b;
  logic              eot;
  logic              at;
  logic              at_next;
  logic [CNT_W-1:0]  cnt_inc;
  num_t              parsed;
  logic signed [17:0] row_m1;
  logic signed [8:0]  cpr_s;
  logic signed [26:0] prod;
  logic signed [33:0] tgt_s;

  function automatic num_t parse_char(num_t cur, logic [7:0] c);
    num_t        nx;
    logic        blank;
    logic        sign;
    logic        digit;
    logic [35:0] t;
    nx    = cur;
    blank = (c == CH_SPACE) || (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    sign  = (c == CH_MINUS) || (c == CH_PLUS);
    digit = (c >= CH_0) && (c <= CH_9);
    t     = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0} + {32'd0, c[3:0]};
    if (cur.phase == NP_STOP) begin
      nx = cur;
    end else if (cur.phase == NP_BLANK && blank) begin
      nx = cur;
    end else if (cur.phase == NP_BLANK && sign) begin
      nx.neg   = (c == CH_MINUS);
      nx.phase = NP_SIGN;
    end else if (digit) begin
      nx.acc   = (t > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : t[31:0];
      nx.phase = NP_DIGIT;
    end else begin
      nx.phase = NP_STOP;
    end
    return nx;
  endfunction

  function automatic job_t field_end(logic vt, num_t n);
    job_t j;
    j = '0;
    if (vt) begin
      j.kind = KIND_END;
    end else begin
      j.kind = KIND_INT;
      if (n.phase == NP_DIGIT) begin
        j.valid = 1'b1;
        j.mag   = n.acc;
        j.neg   = n.neg;
      end
    end
    return j;
  endfunction

  function automatic job_t not_found();
    job_t j;
    j      = '0;
    j.kind = KIND_NONE;
    return j;
  endfunction

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;

  // one bubble after a write while the target index register catches up
  assign in_ch.ready = !q_stat.full && !hold_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign b           = in_ch.text_byte;
  assign eot         = in_ch.end_of_text;

  // target = col + cpr*(row-1) - 1, signed
  assign row_m1 = $signed({2'b00, row_r}) - 18'sd1;
  assign cpr_s  = $signed({1'b0, cpr_r});
  assign prod   = cpr_s * row_m1;
  assign tgt_s  = $signed({{7{prod[26]}}, prod}) + $signed({26'd0, col_r}) - 34'sd1;

  assign at      = !scan_r && tgt_ok_r && (cnt_r == tgt_r);
  assign cnt_inc = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
  assign at_next = tgt_ok_r && (cnt_inc == tgt_r);
  assign parsed  = parse_char(num_r, b);

  always_comb begin
    cnt_nxt  = cnt_r;
    scan_nxt = scan_r;
    num_nxt  = num_r;
    push     = 1'b0;
    push_job = '0;
    if (in_fire) begin
      if (b == CH_NUL) begin
        if (!scan_r) begin
          push     = 1'b1;
          push_job = at ? field_end(vt_r, num_r) : not_found();
        end
        cnt_nxt  = '0;
        scan_nxt = 1'b0;
        num_nxt  = NUM_CLEAR;
      end else begin
        if (b == CH_TAB || b == CH_LF) begin
          cnt_nxt = cnt_inc;
          num_nxt = NUM_CLEAR;
          if (at) begin
            push     = 1'b1;
            push_job = field_end(vt_r, num_r);
            scan_nxt = 1'b1;
          end else if (eot && !scan_r) begin
            // delimiter may just have opened the wanted field
            push     = 1'b1;
            push_job = at_next ? field_end(vt_r, NUM_CLEAR) : not_found();
          end
        end else if (at) begin
          if (vt_r) begin
            push             = 1'b1;
            push_job.kind    = KIND_BYTE;
            push_job.fbyte   = b;
            push_job.has_end = eot;
          end else begin
            num_nxt = parsed;
            if (eot) begin
              push     = 1'b1;
              push_job = field_end(vt_r, parsed);
            end
          end
        end else if (eot && !scan_r) begin
          push     = 1'b1;
          push_job = not_found();
        end
        if (eot) begin
          cnt_nxt  = '0;
          scan_nxt = 1'b0;
          num_nxt  = NUM_CLEAR;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r    <= 16'd1;
      col_r    <= 8'd1;
      cpr_r    <= 8'd10;
      vt_r     <= 1'b0;
      tgt_r    <= '0;
      tgt_ok_r <= 1'b1;
      hold_r   <= 1'b0;
      cnt_r    <= '0;
      scan_r   <= 1'b0;
      num_r    <= NUM_CLEAR;
    end else begin
      hold_r   <= cfg_fire;
      tgt_r    <= tgt_s[CNT_W-1:0];
      tgt_ok_r <= !tgt_s[33] &&
                  (tgt_s < $signed({{(34-CNT_W){1'b0}}, CNT_MAX}));
      cnt_r    <= cnt_nxt;
      scan_r   <= scan_nxt;
      num_r    <= num_nxt;
      if (cfg_fire) begin
        unique case (cfg_ch.addr)
          CFG_ROW:  row_r <= cfg_ch.data[15:0];
          CFG_COL:  col_r <= cfg_ch.data[7:0];
          CFG_CPR:  cpr_r <= cfg_ch.data[7:0];
          CFG_TYPE: vt_r  <= cfg_ch.data[0];
          default: ;
        endcase
      end
    end
  end

  `DFE_ASSERT(a_cfg_bubble, cfg_fire |=> !in_ch.ready, "byte taken right after a register write")
  `DFE_ASSERT(a_push_has_room, push |-> !q_stat.full, "request pushed into a full queue")

endmodule

`default_nettype wire

FILE: rtl/dfe_queue.sv
// ----------------------------------------------------------------------------
// dfe_queue
// Short request FIFO between the classifying front and the result back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dfe_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  dfe_pkg::job_t    push_job,
  input  logic             pop,
  output dfe_pkg::job_t    head,
  output dfe_pkg::q_stat_t stat
);
  import dfe_pkg::*;

  localparam logic [Q_PTR_W-1:0] PTR_LAST = Q_PTR_W'(Q_DEPTH - 1);
  localparam logic [Q_PTR_W:0]   CNT_FULL = (Q_PTR_W + 1)'(Q_DEPTH);

  job_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W:0]   cnt_r;

  function automatic logic [Q_PTR_W-1:0] ptr_inc(logic [Q_PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == CNT_FULL);
  assign stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  `DFE_ASSERT(a_no_overflow, push |-> !stat.full, "queue overflow")
  `DFE_ASSERT(a_no_underflow, pop |-> !stat.empty, "queue underflow")
  `DFE_ASSERT(a_cnt_bound, cnt_r <= CNT_FULL, "queue count past depth")

endmodule

`default_nettype wire

FILE: rtl/dfe_back.sv
// ----------------------------------------------------------------------------
// dfe_back
// Drains queued requests into the registered result channel, expanding a
// string byte with a trailing end marker into two results.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dfe_back (
  input  logic             clk,
  input  logic             rst_n,
  input  dfe_pkg::job_t    head,
  input  dfe_pkg::q_stat_t q_stat,
  output logic             pop,
  dfe_out_if.source        out_ch
);
  import dfe_pkg::*;

  logic        out_valid_r;
  logic [1:0]  kind_r;
  logic [7:0]  fbyte_r;
  logic [31:0] value_r;
  logic        nvalid_r;
  logic        last_r;
  logic        pend_end_r;

  logic        load;
  logic [31:0] head_value;

  assign load = !out_valid_r || out_ch.ready;
  assign pop  = load && !pend_end_r && !q_stat.empty;

  // magnitude is capped at 2^31, so only the positive side needs clamping
  assign head_value = head.neg ? (32'd0 - head.mag)
                               : (head.mag[31] ? 32'h7FFF_FFFF : head.mag);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_end_r  <= 1'b0;
      last_r      <= 1'b0;
    end else if (load) begin
      if (pend_end_r) begin
        out_valid_r <= 1'b1;
        last_r      <= 1'b1;
        pend_end_r  <= 1'b0;
      end else if (!q_stat.empty) begin
        out_valid_r <= 1'b1;
        last_r      <= !head.has_end;
        pend_end_r  <= head.has_end;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_end_r) begin
        kind_r   <= KIND_END;
        fbyte_r  <= 8'd0;
        value_r  <= 32'd0;
        nvalid_r <= 1'b0;
      end else begin
        kind_r   <= head.kind;
        fbyte_r  <= head.fbyte;
        value_r  <= head_value;
        nvalid_r <= head.valid;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_kind  = kind_r;
  assign out_ch.field_byte   = fbyte_r;
  assign out_ch.int_value    = $signed(value_r);
  assign out_ch.number_valid = nvalid_r;
  assign out_ch.last_of_run  = last_r;

  `DFE_ASSERT(a_end_after_byte,
    pend_end_r |-> out_valid_r && (kind_r == KIND_BYTE) && !last_r,
    "pending string end without a byte result in the output register")

endmodule

`default_nettype wire

FILE: test/delimited_field_extractor_core_tb.sv
// ----------------------------------------------------------------------------
// delimited_field_extractor_core_tb
// Self-checking bench for the tab/newline field extractor. Text streams go
// in over the byte channel. Every accepted byte runs through a behavioral
// predictor of the field counter and number parser, and every accepted
// result is compared against the oldest prediction. Directed texts come
// first, then random texts under changing register settings, an output
// hold-off that backs the block up, and a final stretch with no idling.
// ----------------------------------------------------------------------------
module delimited_field_extractor_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dfe_pkg::*;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int HOLD_CYCLES = 150;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  fbyte;
    logic [31:0] ival;
    logic        nvalid;
    logic        last_flag;
  } field_result_t;

  logic clk;
  logic rst_n;

  dfe_in_if  in_bus ();
  dfe_out_if out_bus ();
  dfe_cfg_if cfg_bus ();

  delimited_field_extractor_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // register copies
  logic [15:0] want_row;
  logic [7:0]  want_col;
  logic [7:0]  row_width;
  logic        string_mode;

  // scan and parse state
  logic [CNT_W-1:0] fields_seen;
  logic             field_done;
  logic [31:0]      mag;
  logic             minus;
  logic [1:0]       parse_phase;

  field_result_t expected_results[$];
  field_result_t step_results[$];
  logic [7:0]    text_bytes[$];

  int     error_count = 0;
  int     sent_bytes  = 0;
  longint cycle_count = 0;
  bit     in_gaps     = 1;
  bit     out_stalls  = 1;
  bit     hold_request = 0;
  bit     hold_active  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_number();
    mag = 32'd0;
    minus = 1'b0;
    parse_phase = NP_BLANK;
  endfunction

  function automatic void clear_text();
    fields_seen = '0;
    field_done = 1'b0;
    clear_number();
  endfunction

  function automatic bit on_wanted_field();
    longint r, c, w, idx;
    r = want_row;
    c = want_col;
    w = row_width;
    idx = c + w * (r - 1) - 1;
    if (field_done || idx < 0 || idx >= (longint'(1) << CNT_W) - 1) return 1'b0;
    return longint'(fields_seen) == idx;
  endfunction

  function automatic void add_result(logic [1:0] kind, logic [7:0] fbyte,
                                     logic [31:0] ival, logic nvalid);
    step_results.push_back('{kind: kind, fbyte: fbyte, ival: ival, nvalid: nvalid,
                             last_flag: 1'b0});
  endfunction

  function automatic void add_field_end();
    if (string_mode)
      add_result(KIND_END, 8'd0, 32'd0, 1'b0);
    else if (parse_phase == NP_DIGIT)
      add_result(KIND_INT, 8'd0,
                 minus ? 32'd0 - mag : (mag >= MAG_LIMIT ? 32'h7FFF_FFFF : mag), 1'b1);
    else
      add_result(KIND_INT, 8'd0, 32'd0, 1'b0);
  endfunction

  function automatic void parse_number_byte(logic [7:0] b);
    longint unsigned grown;
    if (parse_phase == NP_STOP) return;
    if (parse_phase == NP_BLANK) begin
      if (b == CH_SPACE || b == CH_VT || b == CH_FF || b == CH_CR) return;
      if (b == CH_MINUS || b == CH_PLUS) begin
        minus = (b == CH_MINUS);
        parse_phase = NP_SIGN;
        return;
      end
    end
    if (b >= CH_0 && b <= CH_9) begin
      grown = longint'(mag) * 10 + (b - CH_0);
      if (grown > MAG_LIMIT) grown = MAG_LIMIT;
      mag = grown[31:0];
      parse_phase = NP_DIGIT;
    end else begin
      parse_phase = NP_STOP;
    end
  endfunction

  // end of text: not-found only if the wanted field never closed
  function automatic void close_text();
    if (!field_done) begin
      if (on_wanted_field()) add_field_end();
      else add_result(KIND_NONE, 8'd0, 32'd0, 1'b0);
    end
    clear_text();
  endfunction

  function automatic void predict_text_byte(logic [7:0] b, logic eot);
    bit wanted;
    step_results.delete();
    if (b == CH_NUL) begin
      close_text();
    end else begin
      wanted = on_wanted_field();
      if (b == CH_TAB || b == CH_LF) begin
        if (wanted) begin
          add_field_end();
          field_done = 1'b1;
        end
        if (fields_seen != '1) fields_seen++;
        clear_number();
      end else if (wanted) begin
        if (string_mode) add_result(KIND_BYTE, b, 32'd0, 1'b0);
        else parse_number_byte(b);
      end
      if (eot) close_text();
    end
    if (step_results.size() > 0) step_results[step_results.size() - 1].last_flag = 1'b1;
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    field_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_results.size() == 0) begin
        $error("result_kind: expected none, actual %0d", out_bus.result_kind);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("result_kind", want.kind, out_bus.result_kind);
        check_field("field_byte", want.fbyte, out_bus.field_byte);
        check_field("int_value", want.ival, out_bus.int_value);
        check_field("number_valid", want.nvalid, out_bus.number_valid);
        check_field("last_of_run", want.last_flag, out_bus.last_of_run);
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  initial begin : output_holdoff
    forever begin
      wait (hold_request);
      hold_request = 0;
      hold_active = 1;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_active = 0;
    end
  end

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_active) begin
        out_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else if (out_stalls && $urandom_range(0, 5) == 0) begin
        out_bus.ready <= 1'b0;
        stall_left = $urandom_range(1, 11) - 1;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_text_byte(input logic [7:0] b, input logic eot);
    int gap;
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_bus.valid <= 1'b1;
    in_bus.text_byte <= b;
    in_bus.end_of_text <= eot;
    do @(posedge clk); while (!in_bus.ready);
    predict_text_byte(b, eot);
    sent_bytes++;
  endtask

  task automatic send_string(input string s, input bit eot_last);
    for (int i = 0; i < s.len(); i++) send_text_byte(s[i], eot_last && i == s.len() - 1);
  endtask

  // let the pipeline empty; a byte may still be in flight with nothing expected
  task automatic wait_idle();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_ADDR_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.addr <= idx;
    cfg_bus.data <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      CFG_ROW:  want_row = value;
      CFG_COL:  want_col = value[7:0];
      CFG_CPR:  row_width = value[7:0];
      CFG_TYPE: string_mode = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == CH_TAB || b == CH_LF);
    return b;
  endfunction

  function automatic logic [7:0] delimiter();
    return $urandom_range(0, 1) ? CH_TAB : CH_LF;
  endfunction

  function automatic logic [15:0] pick_row();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(1, 4));
    endcase
  endfunction

  // upper data bits are don't-care for the 8-bit registers
  function automatic logic [15:0] pick_narrow();
    logic [7:0] v;
    case ($urandom_range(0, 9))
      0:       v = 8'd0;
      1:       v = 8'hFF;
      2:       v = 8'($urandom);
      default: v = 8'($urandom_range(1, 6));
    endcase
    return {8'($urandom), v};
  endfunction

  task automatic randomize_config();
    wait_idle();
    if ($urandom_range(0, 3) != 0) write_register(CFG_ROW, pick_row());
    if ($urandom_range(0, 3) != 0) write_register(CFG_COL, pick_narrow());
    if ($urandom_range(0, 3) != 0) write_register(CFG_CPR, pick_narrow());
    if ($urandom_range(0, 3) != 0) write_register(CFG_TYPE, 16'($urandom));
    if ($urandom_range(0, 7) == 0)
      write_register(CFG_ADDR_W'($urandom_range(4, 15)), 16'($urandom));
  endtask

  function automatic void append_number();
    logic [7:0] blanks[4] = '{CH_SPACE, CH_VT, CH_FF, CH_CR};
    int n_digit;
    repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 2))
      text_bytes.push_back(blanks[$urandom_range(0, 3)]);
    case ($urandom_range(0, 3))
      0: text_bytes.push_back(CH_MINUS);
      1: text_bytes.push_back(CH_PLUS);
      default: ;
    endcase
    n_digit = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 4);
    repeat (n_digit) text_bytes.push_back(8'(CH_0 + $urandom_range(0, 9)));
    if ($urandom_range(0, 5) == 0) text_bytes.push_back(plain_byte());
  endfunction

  // mostly well-formed rows of fields, now and then raw noise
  task automatic send_random_text();
    int n_fields;
    bit eot_last;
    text_bytes.delete();
    eot_last = 1'b0;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 30)) text_bytes.push_back(8'($urandom));
      eot_last = $urandom_range(0, 1);
    end else begin
      n_fields = $urandom_range(1, 24);
      for (int i = 0; i < n_fields; i++) begin
        case ($urandom_range(0, 4))
          0, 1, 2: append_number();
          3:       repeat ($urandom_range(1, 6)) text_bytes.push_back(plain_byte());
          default: ;
        endcase
        if (i < n_fields - 1) text_bytes.push_back(delimiter());
      end
      case ($urandom_range(0, 3))
        0: text_bytes.push_back(CH_NUL);
        1: begin
          text_bytes.push_back(CH_NUL);
          eot_last = 1'b1;
        end
        2: begin
          if (text_bytes.size() == 0) text_bytes.push_back(CH_NUL);
          eot_last = 1'b1;
        end
        default: begin
          text_bytes.push_back(delimiter());
          eot_last = 1'b1;
        end
      endcase
    end
    foreach (text_bytes[i]) send_text_byte(text_bytes[i], eot_last && i == text_bytes.size() - 1);
  endtask

  // ---------------------------------------------------------------- tests

  // reset settings: field 0, integer mode
  task automatic test_integer_fields();
    send_text_byte(CH_CR, 1'b0);
    send_text_byte(CH_VT, 1'b0);
    send_text_byte(CH_FF, 1'b0);
    send_text_byte(CH_SPACE, 1'b0);
    send_string("-9999999999\t", 1'b0);
    send_text_byte(CH_NUL, 1'b0);   // field already closed: no result
    send_string("+9999999999", 1'b1);
    send_string("x", 1'b1);         // no digits
  endtask

  task automatic test_string_fields();
    wait_idle();
    write_register(CFG_TYPE, 16'hFFFF);
    write_register(CFG_COL, 16'hA502);
    send_text_byte("a", 1'b0);
    send_text_byte(CH_TAB, 1'b0);
    send_text_byte(8'hFF, 1'b0);
    send_text_byte(8'h80, 1'b1);    // last byte plus end marker
    send_text_byte(CH_TAB, 1'b0);
    send_text_byte(CH_TAB, 1'b0);   // empty wanted field
    send_text_byte(CH_NUL, 1'b0);
  endtask

  task automatic test_field_select();
    wait_idle();
    write_register(CFG_ROW, 16'd2);
    write_register(CFG_COL, 16'd1);
    write_register(CFG_CPR, 16'd1);
    send_text_byte(CH_TAB, 1'b0);
    send_text_byte("k", 1'b0);
    send_text_byte(CH_LF, 1'b1);
    wait_idle();
    write_register(CFG_ROW, 16'hFFFF);
    write_register(CFG_COL, 16'h00FF);
    write_register(CFG_CPR, 16'hFFFF);
    write_register(CFG_ADDR_W'(4), 16'h0000);
    write_register(CFG_ADDR_W'(15), 16'hFFFF);
    send_text_byte("z", 1'b1);
    wait_idle();
    write_register(CFG_ROW, 16'd0);  // wanted field index 253
    write_register(CFG_CPR, 16'd1);
    send_text_byte(CH_NUL, 1'b1);
    // move the wanted field behind the scan in the middle of a text
    wait_idle();
    write_register(CFG_ROW, 16'd1);
    write_register(CFG_COL, 16'd3);
    send_text_byte(CH_TAB, 1'b0);
    send_text_byte(CH_TAB, 1'b0);
    wait_idle();
    write_register(CFG_COL, 16'd1);
    send_text_byte("q", 1'b1);
  endtask

  task automatic test_random_texts(input int n_bytes, input bit idling);
    int stop_at;
    in_gaps = idling;
    out_stalls = idling;
    stop_at = sent_bytes + n_bytes;
    while (sent_bytes < stop_at) begin
      if ($urandom_range(0, 3) == 0) randomize_config();
      send_random_text();
    end
  endtask

  // a long string field behind a held output fills the queue and stalls input
  task automatic test_output_holdoff();
    wait_idle();
    write_register(CFG_TYPE, 16'($urandom) | 16'd1);
    write_register(CFG_ROW, 16'd1);
    write_register(CFG_COL, 16'd1);
    in_gaps = 0;
    hold_request = 1;
    repeat (48) send_text_byte(plain_byte(), 1'b0);
    send_text_byte(CH_NUL, 1'b0);
    in_gaps = 1;
  endtask

  initial begin
    in_bus.valid = 1'b0;
    in_bus.text_byte = 8'd0;
    in_bus.end_of_text = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.addr = '0;
    cfg_bus.data = '0;
    rst_n = 1'b0;
    want_row = 16'd1;
    want_col = 8'd1;
    row_width = 8'd10;
    string_mode = 1'b0;
    clear_text();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_integer_fields();
    test_string_fields();
    test_field_select();
    test_random_texts(1200, 1'b1);
    test_output_holdoff();
    test_random_texts(300, 1'b0);

    wait_idle();
    repeat (8) @(posedge clk);
    if (error_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
